FILE: design/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and constants for the gcd/lcm unit
// Port widths, the default operand width and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package gcl_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int OPERAND_PORT_W = 32;
  localparam int GCD_PORT_W = 32;
  localparam int LCM_PORT_W = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture operands, handle zero operands
    logic common_step;  // strip a shared factor of two
    logic reduce_step;  // one binary gcd reduction
    logic fin_gcd;      // restore the shared factors of two
    logic div_init;     // start dividing a by the gcd
    logic div_step;     // one quotient bit
    logic mult;         // form the lcm
  } gcl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_case;    // an incoming operand is zero
    logic both_even;
    logic equal;
    logic cnt_zero;
  } gcl_status_t;

endpackage

`default_nettype wire

FILE: design/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// Binary gcd, then lcm as (a / gcd) * b at double width.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Transfer
// command   start, busy, operand_a, operand_b         start && !busy
// result    done, gcd_value, lcm_value, lcm_undefined done (one cycle)
//
// A zero operand goes from the transfer straight to the result. Otherwise the
// sequencer runs the gcd loops (one shift or subtract per step, each loop
// ending in an exit check), restores the shared factors of two, runs the
// bit-serial divider, forms the lcm in the multiplier and then presents the
// result.
// Synchronous reset returns the sequencer to idle; results are not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_lcm_unit
  import gcl_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [OPERAND_PORT_W-1:0] operand_a,
  input  wire logic [OPERAND_PORT_W-1:0] operand_b,
  output logic                           done,
  output logic [GCD_PORT_W-1:0]          gcd_value,
  output logic [LCM_PORT_W-1:0]          lcm_value,
  output logic                           lcm_undefined
);

  gcl_cmd_t    cmd;
  gcl_status_t status;

  gcl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  gcl_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .cmd           (cmd),
    .status        (status),
    .gcd_value     (gcd_value),
    .lcm_value     (lcm_value),
    .lcm_undefined (lcm_undefined)
  );

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (done && lcm_undefined) |-> (gcd_value == '0 && lcm_value == '0))
    else $error("undefined lcm with nonzero results");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !lcm_undefined) |-> (gcd_value != '0))
    else $error("zero gcd for nonzero operands");
`endif

endmodule

`default_nettype wire

FILE: design/gcl_ctrl.sv
// ----------------------------------------------------------------------------
// gcl_ctrl: sequencer of the gcd/lcm unit
// Steps the datapath through binary gcd, division and multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_ctrl
  import gcl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire gcl_status_t status,
  output gcl_cmd_t         cmd,
  output logic             busy,
  output logic             done
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_COMMON = 3'd1;
  localparam logic [2:0] ST_REDUCE = 3'd2;
  localparam logic [2:0] ST_FIN    = 3'd3;
  localparam logic [2:0] ST_DIVIDE = 3'd4;
  localparam logic [2:0] ST_MULT   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = status.zero_case ? ST_DONE : ST_COMMON;
        end
      end
      ST_COMMON: begin
        if (status.both_even) begin
          cmd.common_step = 1'b1;
        end else begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.equal) begin
          state_next = ST_FIN;
        end else begin
          cmd.reduce_step = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.fin_gcd = 1'b1;
        cmd.div_init = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.cnt_zero) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

`default_nettype wire

FILE: design/gcl_datapath.sv
// ----------------------------------------------------------------------------
// gcl_datapath: arithmetic of the gcd/lcm unit
// Binary gcd registers, a bit-serial divider and a combinational multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_datapath
  import gcl_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic [OPERAND_PORT_W-1:0] operand_a,
  input  wire logic [OPERAND_PORT_W-1:0] operand_b,
  input  wire gcl_cmd_t                  cmd,
  output gcl_status_t                    status,
  output logic [GCD_PORT_W-1:0]          gcd_value,
  output logic [LCM_PORT_W-1:0]          lcm_value,
  output logic                           lcm_undefined
);

  localparam int W = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]   opa;
  logic [W-1:0]   opb;
  logic [W-1:0]   a_reg;
  logic [W-1:0]   b_reg;
  logic [W-1:0]   x;
  logic [W-1:0]   y;
  logic [CW-1:0]  k;
  logic [W-1:0]   g;
  logic [W-1:0]   quo;
  logic [W-1:0]   rem;
  logic [CW-1:0]  cnt;
  logic [W:0]     rem_shift;
  logic [W-1:0]   rem_diff;
  logic [W-1:0]   x_minus_y;
  logic [W-1:0]   y_minus_x;
  logic [2*W-1:0] product;

  assign opa = operand_a[W-1:0];
  assign opb = operand_b[W-1:0];

  assign x_minus_y = x - y;
  assign y_minus_x = y - x;
  assign rem_shift = {rem, quo[W-1]};
  // The remainder stays below g, so the difference fits in W bits.
  assign rem_diff = rem_shift[W-1:0] - g;
  assign product = quo * b_reg;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg <= opa;
      b_reg <= opb;
      x <= opa;
      y <= opb;
      k <= '0;
      // Zero operands finish here; the other paths overwrite the gcd and lcm later.
      gcd_value <= GCD_PORT_W'(opa | opb);
      lcm_value <= '0;
      lcm_undefined <= (opa == '0) && (opb == '0);
    end
    if (cmd.common_step) begin
      x <= x >> 1;
      y <= y >> 1;
      k <= k + 1'b1;
    end
    if (cmd.reduce_step) begin
      // At least one of x and y is odd; both odd shrinks the larger one.
      if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= x_minus_y >> 1;
      end else begin
        y <= y_minus_x >> 1;
      end
    end
    if (cmd.fin_gcd) begin
      g <= x << k;
      gcd_value <= GCD_PORT_W'(x << k);
    end
    if (cmd.div_init) begin
      quo <= a_reg;
      rem <= '0;
      cnt <= CW'(W - 1);
    end
    if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
      if (rem_shift >= {1'b0, g}) begin
        rem <= rem_diff;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
    if (cmd.mult) begin
      lcm_value <= LCM_PORT_W'(product);
    end
  end

  assign status.zero_case = (opa == '0) || (opb == '0);
  assign status.both_even = !x[0] && !y[0];
  assign status.equal = (x == y);
  assign status.cnt_zero = (cnt == '0);

endmodule

`default_nettype wire

FILE: sim/tb_gcd_lcm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gcd_lcm_unit: self-checking testbench for the gcd/lcm unit
// A directed table of operand pairs followed by random pairs, biased toward
// shared factors, zero operands, factors of two and multiples. Every result is
// compared in order with a table of values from the directed table or a Euclid-based predictor.
// ----------------------------------------------------------------------------

module tb_gcd_lcm_unit;
  import gcl_pkg::*;

  localparam int OPW = OPERAND_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 4 * OPW + 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  localparam int DIRECTED_ROWS = 22;
  localparam int TOTAL_ITEMS = DIRECTED_ROWS + RANDOM_ITEMS;

  typedef struct packed {
    logic [GCD_PORT_W-1:0] gcd;
    logic [LCM_PORT_W-1:0] lcm;
    logic                  undef;
  } gcd_lcm_t;

  typedef struct packed {
    logic [OPERAND_PORT_W-1:0] a;
    logic [OPERAND_PORT_W-1:0] b;
    logic                      known;
    gcd_lcm_t                  res;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [OPERAND_PORT_W-1:0] operand_a = '0;
  logic [OPERAND_PORT_W-1:0] operand_b = '0;
  logic                      busy;
  logic                      done;
  logic [GCD_PORT_W-1:0]     gcd_value;
  logic [LCM_PORT_W-1:0]     lcm_value;
  logic                      lcm_undefined;

  logic [OPERAND_PORT_W-1:0] stim_a[0:TOTAL_ITEMS-1];
  logic [OPERAND_PORT_W-1:0] stim_b[0:TOTAL_ITEMS-1];
  logic                      stim_known[0:TOTAL_ITEMS-1];
  gcd_lcm_t                  stim_res[0:TOTAL_ITEMS-1];
  gcd_lcm_t                  expected_tbl[0:TOTAL_ITEMS-1];
  directed_row_t             directed_tbl[0:DIRECTED_ROWS-1];

  int total_items = 0;
  int next_idx = 0;
  int shown_idx = 0;
  int sent_count = 0;
  int recv_count = 0;
  int mismatch_count = 0;
  int idle_pct = 0;
  int cycle_count = 0;

  gcd_lcm_unit #(.OPERAND_WIDTH(OPW)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .gcd_value    (gcd_value),
    .lcm_value    (lcm_value),
    .lcm_undefined(lcm_undefined)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Euclid's remainder loop on the masked operands; lcm is (a / gcd) * b.
  function automatic gcd_lcm_t gcd_lcm_of(input logic [OPERAND_PORT_W-1:0] a_in,
                                          input logic [OPERAND_PORT_W-1:0] b_in);
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    gcd_lcm_t    res;
    mask = (64'd1 << OPW) - 64'd1;
    a = {32'd0, a_in} & mask;
    b = {32'd0, b_in} & mask;
    if (a == 64'd0 && b == 64'd0) begin
      res = '{gcd: '0, lcm: '0, undef: 1'b1};
    end else if (a == 64'd0 || b == 64'd0) begin
      x = a | b;
      res = '{gcd: x[GCD_PORT_W-1:0], lcm: '0, undef: 1'b0};
    end else begin
      x = a;
      y = b;
      while (y != 64'd0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res = '{gcd: x[GCD_PORT_W-1:0], lcm: (a / x) * b, undef: 1'b0};
    end
    return res;
  endfunction

  // Stimulus build, reset, and end of run.
  initial begin : main_seq
    logic [OPERAND_PORT_W-1:0] ra;
    logic [OPERAND_PORT_W-1:0] rb;
    logic [OPERAND_PORT_W-1:0] g;
    logic [OPERAND_PORT_W-1:0] t;
    int mode;
    int n;

    directed_tbl = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 64'h0, 1'b1}},
      '{32'h0000_0000, 32'h0000_0005, 1'b1, '{32'h5, 64'h0, 1'b0}},
      '{32'h0000_0007, 32'h0000_0000, 1'b1, '{32'h7, 64'h0, 1'b0}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 64'h0, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 64'h0, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b0}},
      '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h1, 64'h1, 1'b0}},
      '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h1, 64'hFFFF_FFFF, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h1, 64'hFFFF_FFFF, 1'b0}},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 64'h8000_0000, 1'b0}},
      '{32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h1, 64'h8000_0000, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
      '{32'd2971215073, 32'd1836311903, 1'b0, '0},
      '{32'd12, 32'd18, 1'b0, '0},
      '{32'd4294967291, 32'd4294967279, 1'b0, '0},
      '{32'h8000_0000, 32'h4000_0000, 1'b0, '0},
      '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{32'h6000_0000, 32'h4800_0000, 1'b0, '0},
      '{32'd1024, 32'd3, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
      '{32'd6, 32'd4, 1'b0, '0}
    };

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      stim_a[n] = directed_tbl[n].a;
      stim_b[n] = directed_tbl[n].b;
      stim_known[n] = directed_tbl[n].known;
      stim_res[n] = directed_tbl[n].res;
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      mode = $urandom_range(0, 99);
      ra = $urandom;
      rb = $urandom;
      if (mode < 45) begin
        // Full-range operands, as drawn.
      end else if (mode < 65) begin
        // A shared factor of up to 16 bits keeps both products in range.
        g = $urandom >> $urandom_range(16, 31);
        ra = g * ($urandom >> $urandom_range(16, 31));
        rb = g * ($urandom >> $urandom_range(16, 31));
      end else if (mode < 73) begin
        if ($urandom_range(0, 1) == 0) begin
          ra = '0;
          rb = rb >> $urandom_range(0, 31);
        end else begin
          rb = '0;
          ra = ra >> $urandom_range(0, 31);
        end
      end else if (mode < 76) begin
        ra = '0;
        rb = '0;
      end else if (mode < 84) begin
        rb = $urandom >> $urandom_range(8, 31);
        ra = ($urandom_range(0, 3) == 0) ? rb : rb * $urandom_range(1, 255);
        if ($urandom_range(0, 1) == 0) begin
          t = ra;
          ra = rb;
          rb = t;
        end
      end else if (mode < 92) begin
        ra = ($urandom | 32'd1) << $urandom_range(0, 31);
        rb = ($urandom | 32'd1) << $urandom_range(0, 31);
      end else begin
        ra = $urandom_range(0, 255);
        rb = $urandom_range(0, 255);
      end
      stim_a[DIRECTED_ROWS + n] = ra;
      stim_b[DIRECTED_ROWS + n] = rb;
      stim_known[DIRECTED_ROWS + n] = 1'b0;
      stim_res[DIRECTED_ROWS + n] = '0;
    end
    total_items = TOTAL_ITEMS;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_items || recv_count != sent_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && recv_count == sent_count) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Command driver and result checker share one process, so the oldest
  // expectation is always checked before a new one is recorded.
  always @(posedge clk) begin
    gcd_lcm_t exp_res;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (done) begin
        if (recv_count >= sent_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result with nothing pending: gcd=%h lcm=%h undef=%b",
                     $realtime, gcd_value, lcm_value, lcm_undefined);
        end else begin
          exp_res = expected_tbl[recv_count];
          recv_count++;
          if (gcd_value !== exp_res.gcd || lcm_value !== exp_res.lcm ||
              lcm_undefined !== exp_res.undef) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              if (gcd_value !== exp_res.gcd)
                $display("[%0t] gcd_value: expected %h, got %h",
                         $realtime, exp_res.gcd, gcd_value);
              if (lcm_value !== exp_res.lcm)
                $display("[%0t] lcm_value: expected %h, got %h",
                         $realtime, exp_res.lcm, lcm_value);
              if (lcm_undefined !== exp_res.undef)
                $display("[%0t] lcm_undefined: expected %b, got %b",
                         $realtime, exp_res.undef, lcm_undefined);
            end
          end
        end
      end

      if (start && !busy) begin
        if (stim_known[shown_idx])
          expected_tbl[sent_count] = stim_res[shown_idx];
        else
          expected_tbl[sent_count] = gcd_lcm_of(operand_a, operand_b);
        sent_count++;
      end

      // Sender idling: 36 percent in the first third, 48 in the second, none after.
      idle_pct = (next_idx < total_items / 3) ? 36 :
                 (next_idx < 2 * total_items / 3) ? 48 : 0;
      if (!start || !busy) begin
        if (next_idx < total_items && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          operand_a <= stim_a[next_idx];
          operand_b <= stim_b[next_idx];
          shown_idx = next_idx;
          next_idx++;
        end else begin
          // Idle cycles carry junk operands, which the block must ignore.
          start <= 1'b0;
          operand_a <= $urandom;
          operand_b <= $urandom;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
